[sv/mcs_pkg.sv]
// shared types, sizes and codes of the morton code sorter
// no dependencies; every other file imports this package
package mcs_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int ID_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int POS_W     = 32;
    localparam int CODE_W    = 63;
    localparam int AXIS_W    = 21;
    localparam int GRID_W    = 5;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID  = 3'd6;

    typedef struct packed {
        logic                    action;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   item_id;
        logic [CODE_W-1:0] morton_code;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ID_W-1:0]   id;
    } t_entry;

    // spread 21 bits to every third bit position
    function automatic logic [63:0] spread3(input logic [AXIS_W-1:0] v);
        logic [63:0] r;
        r = {43'd0, v};
        r = (r | (r << 32)) & 64'h001f00000000ffff;
        r = (r | (r << 16)) & 64'h001f0000ff0000ff;
        r = (r | (r << 8))  & 64'h100f00f00f00f00f;
        r = (r | (r << 4))  & 64'h10c30c30c30c30c3;
        r = (r | (r << 2))  & 64'h1249249249249249;
        return r;
    endfunction

endpackage

[sv/mcs_if.sv]
// valid/ready channels of the morton code sorter
// depends on mcs_pkg for the item types
interface mcs_in_if
    import mcs_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mcs_out_if
    import mcs_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/mcs_quant.sv]
// one axis quantizer: |pos-min|*(2^g-1)/(max-min) with a bit-serial divider
// depends on mcs_pkg
module mcs_quant
    import mcs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [POS_W-1:0] i_pos,
    input  logic signed [POS_W-1:0] i_lo,
    input  logic signed [POS_W-1:0] i_hi,
    input  logic [GRID_W-1:0]       i_grid,
    output logic [AXIS_W-1:0]       o_q,
    output logic                    o_err,
    output logic                    o_done
);
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PREP  = 3'd1;
    localparam logic [2:0] PH_SCALE = 3'd2;
    localparam logic [2:0] PH_DIV   = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    logic [2:0]            r_ph;
    logic [POS_W:0]        r_d;
    logic [POS_W:0]        r_span;
    logic [POS_W:0]        r_ad;
    logic                  r_bad;
    logic                  r_over;
    logic [GRID_W-1:0]     r_g;
    logic [POS_W:0]        r_rem;
    logic [AXIS_W-1:0]     r_low;
    logic [AXIS_W-1:0]     r_q;
    logic [GRID_W-1:0]     r_cnt;

    logic [POS_W+AXIS_W:0] w_dvd;
    logic [POS_W+1:0]      w_rem2;
    logic                  w_ge;
    logic [AXIS_W:0]       w_scale;

    assign w_dvd   = ({{AXIS_W{1'b0}}, r_ad} << r_g) - {{AXIS_W{1'b0}}, r_ad};
    assign w_rem2  = {r_rem, r_low[AXIS_W-1]};
    assign w_ge    = w_rem2 >= {1'b0, r_span};
    assign w_scale = ((AXIS_W+1)'(1) << r_g) - (AXIS_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
        end else begin
            unique case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_d    <= {i_pos[POS_W-1], i_pos} - {i_lo[POS_W-1], i_lo};
                        r_span <= {i_hi[POS_W-1], i_hi} - {i_lo[POS_W-1], i_lo};
                        r_g    <= (i_grid > GRID_W'(AXIS_W)) ? GRID_W'(AXIS_W) : i_grid;
                        r_ph   <= PH_PREP;
                    end
                end
                PH_PREP: begin
                    r_ad  <= r_d[POS_W] ? (POS_W+1)'(0) - r_d : r_d;
                    r_bad <= r_span[POS_W] || (r_span == '0);
                    r_ph  <= PH_SCALE;
                end
                PH_SCALE: begin
                    // quotient fits in AXIS_W bits, so the top part is below span
                    r_over <= r_ad > r_span;
                    r_rem  <= w_dvd[POS_W+AXIS_W:AXIS_W];
                    r_low  <= w_dvd[AXIS_W-1:0];
                    r_cnt  <= '0;
                    r_ph   <= PH_DIV;
                end
                PH_DIV: begin
                    r_rem <= w_ge ? 33'(w_rem2 - {1'b0, r_span}) : w_rem2[POS_W:0];
                    r_low <= r_low << 1;
                    r_q   <= {r_q[AXIS_W-2:0], w_ge};
                    r_cnt <= r_cnt + GRID_W'(1);
                    if (r_cnt == GRID_W'(AXIS_W - 1)) begin
                        r_ph <= PH_DONE;
                    end
                end
                PH_DONE: begin
                    r_ph <= PH_IDLE;
                end
                default: begin
                    r_ph <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_ph == PH_DONE;
    assign o_err  = r_bad || r_over;
    assign o_q    = r_bad ? '0 : (r_over ? w_scale[AXIS_W-1:0] : r_q);

endmodule

[sv/mcs_cell.sv]
// one cell of the sorted insertion chain: holds a code and its id
// depends on mcs_pkg
module mcs_cell
    import mcs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_ins,
    input  logic   i_pop,
    input  t_entry i_key,
    input  t_entry i_prev,
    input  logic   i_prev_valid,
    input  logic   i_prev_gt,
    input  t_entry i_next,
    input  logic   i_next_valid,
    output t_entry o_entry,
    output logic   o_valid,
    output logic   o_gt
);
    t_entry r_entry;
    logic   r_valid;

    // empty cells count as greater so the new item lands at the end
    assign o_gt = !r_valid || (r_entry.code > i_key.code);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pop) begin
            r_valid <= i_next_valid;
            r_entry <= i_next;
        end else if (i_ins && o_gt) begin
            r_valid <= i_prev_valid;
            r_entry <= i_prev_gt ? i_prev : i_key;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

[sv/morton_code_sorter_3d_top.sv]
// top level of the 3-d morton code sorter: config, quantizer lanes, sort chain
// depends on mcs_pkg, mcs_if, mcs_quant and mcs_cell
//
// input channel i_in carries items with an action bit. a load item (action 0)
// takes a signed q16.16 position, quantizes each axis against the configured
// bounding box and grid size, interleaves the three values into a 63-bit
// morton code and inserts it into a chain of MAX_ITEMS sort cells, kept in
// ascending code order, ties by load order. after a load no item is taken
// until the three axis lanes have run their 21-step bit-serial divider and
// the code is inserted; it gives no result.
// a fetch item (action 1) pops the head of the chain and gives one result on
// o_out in the cycle after accept: item id, code, status and last. a fetch
// with nothing loaded gives status 2. after the last entry the block takes
// new loads. loads during readout or with a full chain are dropped.
// the user must write configuration through i_cfg_we/i_cfg_idx/i_cfg_wdata
// only while idle; the block does not enforce it. reset (synchronous, active
// low) empties the chain and clears the flags. the result sits in an output
// register; while it is not taken no fetch is accepted.
module morton_code_sorter_3d_top
    import mcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_wdata,
    mcs_in_if.sink               i_in,
    mcs_out_if.source            o_out
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;

    logic signed [POS_W-1:0] r_min_x, r_min_y, r_min_z;
    logic signed [POS_W-1:0] r_max_x, r_max_y, r_max_z;
    logic [GRID_W-1:0]       r_grid;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_sorted;
    logic              r_err;
    logic [CODE_W-1:0] r_key;
    logic              r_ovalid;
    t_out_item         r_oitem;

    logic w_ready, w_acc, w_load, w_fetch, w_pop, w_ins, w_done;
    logic [AXIS_W-1:0] w_qx, w_qy, w_qz;
    logic w_ex, w_ey, w_ez, w_dx, w_dy, w_dz;
    logic [63:0] w_code;
    t_entry w_key;

    t_entry w_entry [MAX_ITEMS];
    logic   w_valid [MAX_ITEMS];
    logic   w_gt    [MAX_ITEMS];

    assign w_ready = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);
    assign w_acc   = i_in.valid && w_ready;
    assign w_load  = w_acc && (i_in.data.action == ACT_LOAD) && !r_sorted
                     && (r_count != CNT_W'(MAX_ITEMS));
    assign w_fetch = w_acc && (i_in.data.action == ACT_FETCH);
    assign w_pop   = w_fetch && (r_count != '0);
    assign w_ins   = r_state == S_INS;
    assign w_done  = w_dx && w_dy && w_dz;
    assign w_code  = spread3(w_qx) | (spread3(w_qy) << 1) | (spread3(w_qz) << 2);
    assign w_key   = '{code: r_key, id: r_count[ID_W-1:0]};

    assign i_in.ready  = w_ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_oitem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_min_z <= '0;
            r_max_x <= 32'sd65536;
            r_max_y <= 32'sd65536;
            r_max_z <= 32'sd65536;
            r_grid  <= 5'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_X: r_min_x <= i_cfg_wdata;
                CFG_MIN_Y: r_min_y <= i_cfg_wdata;
                CFG_MIN_Z: r_min_z <= i_cfg_wdata;
                CFG_MAX_X: r_max_x <= i_cfg_wdata;
                CFG_MAX_Y: r_max_y <= i_cfg_wdata;
                CFG_MAX_Z: r_max_z <= i_cfg_wdata;
                CFG_GRID:  r_grid  <= i_cfg_wdata[GRID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mcs_quant u_qx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_load), .i_pos(i_in.data.pos_x),
        .i_lo(r_min_x), .i_hi(r_max_x), .i_grid(r_grid),
        .o_q(w_qx), .o_err(w_ex), .o_done(w_dx)
    );
    mcs_quant u_qy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_load), .i_pos(i_in.data.pos_y),
        .i_lo(r_min_y), .i_hi(r_max_y), .i_grid(r_grid),
        .o_q(w_qy), .o_err(w_ey), .o_done(w_dy)
    );
    mcs_quant u_qz (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_load), .i_pos(i_in.data.pos_z),
        .i_lo(r_min_z), .i_hi(r_max_z), .i_grid(r_grid),
        .o_q(w_qz), .o_err(w_ez), .o_done(w_dz)
    );

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        mcs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ins       (w_ins),
            .i_pop       (w_pop),
            .i_key       (w_key),
            .i_prev      ((i == 0) ? w_key : w_entry[(i == 0) ? 0 : i - 1]),
            .i_prev_valid((i == 0) ? 1'b1 : w_valid[(i == 0) ? 0 : i - 1]),
            .i_prev_gt   ((i == 0) ? 1'b0 : w_gt[(i == 0) ? 0 : i - 1]),
            .i_next      ((i == MAX_ITEMS - 1) ? w_key
                                               : w_entry[(i == MAX_ITEMS - 1) ? i : i + 1]),
            .i_next_valid((i == MAX_ITEMS - 1) ? 1'b0
                                               : w_valid[(i == MAX_ITEMS - 1) ? i : i + 1]),
            .o_entry     (w_entry[i]),
            .o_valid     (w_valid[i]),
            .o_gt        (w_gt[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sorted <= 1'b0;
            r_err    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_load) begin
                        r_state <= S_BUSY;
                    end
                    if (w_fetch) begin
                        r_ovalid <= 1'b1;
                        if (r_count == '0) begin
                            r_oitem <= '{item_id: '0, morton_code: '0,
                                         status: STAT_EMPTY, last: 1'b0};
                        end else begin
                            r_oitem <= '{item_id: w_entry[0].id,
                                         morton_code: w_entry[0].code,
                                         status: r_err ? STAT_RANGE : STAT_OK,
                                         last: r_count == CNT_W'(1)};
                            if (r_count == CNT_W'(1)) begin
                                r_count  <= '0;
                                r_sorted <= 1'b0;
                                r_err    <= 1'b0;
                            end else begin
                                r_count  <= r_count - CNT_W'(1);
                                r_sorted <= 1'b1;
                            end
                        end
                    end
                end
                S_BUSY: begin
                    if (w_done) begin
                        r_key   <= w_code[CODE_W-1:0];
                        r_err   <= r_err || w_ex || w_ey || w_ez;
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/tb_morton_code_sorter_3d_top.sv]
// testbench of the 3-d morton code sorter: directed and random load/fetch runs
// depends on mcs_pkg, mcs_if and morton_code_sorter_3d_top
module tb_morton_code_sorter_3d_top
    import mcs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [POS_W-1:0]     i_cfg_wdata;

    mcs_in_if  in_ch();
    mcs_out_if out_ch();

    morton_code_sorter_3d_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // predictor state
    longint          box_lo [3];
    longint          box_hi [3];
    int unsigned     grid_sel;
    logic [62:0]     codes [MAX_ITEMS];
    int unsigned     order [MAX_ITEMS];
    int unsigned     n_loaded;
    int unsigned     rd_ptr;
    bit              is_sorted;
    bit              range_err;

    t_out_item       expected_q [$];
    int              errors;
    int              n_results;
    int              n_items;
    bit              idle_en;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] interleave(input logic [63:0] v);
        logic [63:0] r;
        r = v & 64'h1fffff;
        r = (r | r << 32) & 64'h1f00000000ffff;
        r = (r | r << 16) & 64'h1f0000ff0000ff;
        r = (r | r << 8)  & 64'h100f00f00f00f00f;
        r = (r | r << 4)  & 64'h10c30c30c30c30c3;
        r = (r | r << 2)  & 64'h1249249249249249;
        return r;
    endfunction

    function automatic logic [63:0] quantize_axis(input longint p, input int ax);
        int unsigned g;
        logic [63:0] scale;
        longint span, d;
        g = grid_sel > 21 ? 21 : grid_sel;
        scale = (64'd1 << g) - 1;
        span = box_hi[ax] - box_lo[ax];
        d = p - box_lo[ax];
        if (d < 0) d = -d;
        if (span <= 0) begin
            range_err = 1;
            return 0;
        end
        if (d > span) begin
            range_err = 1;
            return scale;
        end
        return (64'(d) * scale) / 64'(span);
    endfunction

    // advance predictor by one accepted item
    task automatic predict_item(input t_in_item it);
        logic [63:0] qx, qy, qz;
        t_out_item r;
        int unsigned i, j, id, p;
        logic [62:0] key;
        if (it.action == ACT_LOAD) begin
            if (is_sorted || n_loaded >= MAX_ITEMS) return;
            qx = quantize_axis(longint'(it.pos_x), 0);
            qy = quantize_axis(longint'(it.pos_y), 1);
            qz = quantize_axis(longint'(it.pos_z), 2);
            codes[n_loaded] = 63'(interleave(qx) | interleave(qy) << 1 | interleave(qz) << 2);
            n_loaded++;
            return;
        end
        if (n_loaded == 0) begin
            r = '0;
            r.status = STAT_EMPTY;
            expected_q = {expected_q, r};
            return;
        end
        if (!is_sorted) begin
            for (i = 0; i < n_loaded; i++) order[i] = i;
            for (i = 1; i < n_loaded; i++) begin
                id = order[i];
                key = codes[id];
                j = i;
                while (j > 0 && codes[order[j-1]] > key) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = id;
            end
            is_sorted = 1;
            rd_ptr = 0;
        end
        p = rd_ptr < n_loaded ? rd_ptr : n_loaded - 1;
        id = order[p];
        r.item_id = ID_W'(id);
        r.morton_code = codes[id];
        r.status = range_err ? STAT_RANGE : STAT_OK;
        r.last = (p + 1 == n_loaded);
        expected_q = {expected_q, r};
        if (r.last) begin
            n_loaded = 0; rd_ptr = 0; is_sorted = 0; range_err = 0;
        end else begin
            rd_ptr = p + 1;
        end
    endtask

    // receiver: random stalls, compare with oldest expectation
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                gap = $urandom_range(1, 16);
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $error("unexpected result id %0d", out_ch.data.item_id);
                errors++;
            end else begin
                t_out_item e;
                e = expected_q.pop_front();
                if (e.item_id !== out_ch.data.item_id) begin
                    $error("item_id exp %0d got %0d", e.item_id, out_ch.data.item_id);
                    errors++;
                end
                if (e.morton_code !== out_ch.data.morton_code) begin
                    $error("morton_code exp %h got %h", e.morton_code,
                           out_ch.data.morton_code);
                    errors++;
                end
                if (e.status !== out_ch.data.status) begin
                    $error("status exp %0d got %0d", e.status, out_ch.data.status);
                    errors++;
                end
                if (e.last !== out_ch.data.last) begin
                    $error("last exp %0d got %0d", e.last, out_ch.data.last);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input logic act, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        t_in_item it;
        int gap;
        it.action = act; it.pos_x = x; it.pos_y = y; it.pos_z = z;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.data  = it;
        in_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(it);
        n_items++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_MIN_X: box_lo[0] = longint'($signed(v));
            CFG_MIN_Y: box_lo[1] = longint'($signed(v));
            CFG_MIN_Z: box_lo[2] = longint'($signed(v));
            CFG_MAX_X: box_hi[0] = longint'($signed(v));
            CFG_MAX_Y: box_hi[1] = longint'($signed(v));
            CFG_MAX_Z: box_hi[2] = longint'($signed(v));
            CFG_GRID:  grid_sel = v[4:0];
            default: ;
        endcase
    endtask

    task automatic set_box(input logic [31:0] lo, input logic [31:0] hi,
                           input logic [4:0] g);
        write_reg(CFG_MIN_X, lo); write_reg(CFG_MIN_Y, lo); write_reg(CFG_MIN_Z, lo);
        write_reg(CFG_MAX_X, hi); write_reg(CFG_MAX_Y, hi); write_reg(CFG_MAX_Z, hi);
        write_reg(CFG_GRID, {27'd0, g});
    endtask

    // send count fetch items, enough to read out the rest of the current set
    task automatic read_out(input int count);
        repeat (count) send_item(ACT_FETCH, $urandom, $urandom, $urandom);
    endtask

    task automatic test_directed();
        send_item(ACT_FETCH, 0, 0, 0);                    // empty fetch
        send_item(ACT_LOAD, 32'h8000, 32'h4000, 32'hc000);
        send_item(ACT_LOAD, 0, 0, 0);
        send_item(ACT_LOAD, 32'h10000, 32'h10000, 32'h10000);
        send_item(ACT_LOAD, 0, 0, 0);                     // tie with id 1
        send_item(ACT_LOAD, 32'h7fffffff, 32'h80000000, 32'hffffffff); // above one
        send_item(ACT_FETCH, 0, 0, 0);
        send_item(ACT_LOAD, 32'h1234, 0, 0);              // dropped during readout
        read_out(4);
        send_item(ACT_FETCH, 0, 0, 0);                    // empty again
        drain_results();
        set_box(32'h80000000, 32'h7fffffff, 5'd21);       // widest box, large grid
        send_item(ACT_LOAD, 32'h80000000, 32'h80000000, 32'h80000000);
        send_item(ACT_LOAD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_item(ACT_LOAD, 0, 32'h7fffffff, 32'h80000000);
        read_out(3);
        drain_results();
        set_box(32'h10000, 32'h10000, 5'd31);             // empty span, grid over 21
        send_item(ACT_LOAD, 32'h10000, 0, 32'h5);
        read_out(1);
        drain_results();
        set_box(0, 32'h10000, 5'd0);                      // grid 0
        send_item(ACT_LOAD, 32'h8000, 32'hffff, 32'h1);
        send_item(ACT_LOAD, 32'h9000, 32'h1, 32'h2);
        read_out(2);
        drain_results();
    endtask

    task automatic test_random();
        int sets, k, n;
        logic [31:0] lo, hi;
        for (sets = 0; sets < 30; sets++) begin
            if (sets == 22) idle_en = 0;
            drain_results();
            case ($urandom_range(0, 3))
                0: begin lo = $urandom; hi = $urandom; end
                1: begin lo = 32'h80000000; hi = 32'h7fffffff; end
                default: begin lo = $urandom_range(0, 32'hffff) - 32'h8000;
                    hi = lo + $urandom_range(1, 32'h40000); end
            endcase
            set_box(lo, hi, 5'($urandom_range(1, 21)));
            n = $urandom_range(1, 24);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(ACT_FETCH, $urandom, $urandom, $urandom);
                else if ($urandom_range(0, 3) == 0)
                    send_item(ACT_LOAD, $urandom, $urandom, $urandom);
                else
                    send_item(ACT_LOAD, lo + $urandom_range(0, 32'hffff),
                              lo + $urandom_range(0, 32'hffff),
                              hi - $urandom_range(0, 32'hffff));
            end
            read_out(n_loaded != 0 ? n_loaded - rd_ptr : 1);
        end
    endtask

    initial begin
        errors = 0; n_results = 0; n_items = 0; idle_en = 1;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        in_ch.valid = 1'b0; in_ch.data = '0;
        box_lo = '{0, 0, 0}; box_hi = '{65536, 65536, 65536}; grid_sel = 10;
        n_loaded = 0; rd_ptr = 0; is_sorted = 0; range_err = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        drain_results();
        $display("sent %0d items, checked %0d results over box and grid settings",
                 n_items, n_results);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[sim.f]
sv/mcs_pkg.sv
sv/mcs_if.sv
sv/mcs_quant.sv
sv/mcs_cell.sv
sv/morton_code_sorter_3d_top.sv
tb/tb_morton_code_sorter_3d_top.sv
